### src/oalt_pkg.sv
// -----------------------------------------------------------------------------
// oalt_pkg: shared types and constants of the ordered array list table
// Request and result layouts, store geometry, operation codes and FSM states.
// -----------------------------------------------------------------------------
package oalt_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_LOCATE = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [5:0]         found_index;
		logic signed [31:0] read_value;
		logic [6:0]         length;
		logic               empty_res;
		logic               full_res;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_DRAIN,
		ST_PUT,
		ST_LOCATE,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

### src/ordered_array_list_table.sv
// -----------------------------------------------------------------------------
// ordered_array_list_table: positional list of signed words in a single store
// Insert, delete, locate and read on a list held in a 64-entry synchronous RAM.
// -----------------------------------------------------------------------------
// Usage:
//   A request (req) is taken on a clock edge with start high and busy low.
//   busy stays high until the result has been presented. Exactly one result
//   per request is driven on res for a single cycle, marked by done; the
//   receiver must take it then, as there is no back-pressure.
//   capacity is written through cfg_we / cfg_wdata while the block is idle.
//   That is the user's duty; the block itself does not enforce it.
// Operations (a refused request leaves the list as it is):
//   insert: shifts later entries up one place when needed, then writes the word
//   delete: shifts later entries down one place when any lie above the position
//   locate: one RAM read per entry, stops at the first match
//   read:   one RAM read when the position is valid
//   busy falls in the cycle after done, so the next request is taken at the
//   earliest on the edge that ends that cycle. Shifts run at one entry per
//   cycle: the single RAM read port paces every walk.
// Reset clears the length to zero and sets capacity to 64; the RAM holds
// no reset, and only words below the current length are ever used.
// -----------------------------------------------------------------------------
module ordered_array_list_table
	import oalt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	output logic       done,
	output res_t       res
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  ptr_q;
	req_t              req_q;
	logic              ok_q;
	logic [5:0]        fidx_q;
	logic [31:0]       rval_q;

	logic [31:0]       mem [DEPTH];
	logic [31:0]       mem_rdata_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;

	logic              accept;
	logic              ins_ok, del_ok, rd_ok, match;
	logic [CNT_W-1:0]  eff_cap;

	logic              rd_issue;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;
	logic              cnt_inc, cnt_dec;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			eff_cap = CNT_W'(DEPTH);
		end
	end

	assign ins_ok = (req.position <= count_q) && (count_q < eff_cap)
		&& (count_q < CNT_W'(DEPTH));
	assign del_ok = (req.position < count_q);
	assign rd_ok  = (req.position < count_q);
	assign match  = rd_vld_s1 && (mem_rdata_q == req_q.value);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.func)
						FN_INSERT: begin
							if (!ins_ok) begin
								state_d = ST_DONE;
							end else if (req.position < count_q) begin
								state_d = ST_SHIFT_UP;
							end else begin
								state_d = ST_PUT;
							end
						end
						FN_DELETE: begin
							if (del_ok && (req.position + CNT_W'(1) < count_q)) begin
								state_d = ST_SHIFT_DN;
							end else begin
								state_d = ST_DONE;
							end
						end
						FN_LOCATE: state_d = ST_LOCATE;
						FN_READ:   state_d = rd_ok ? ST_READ : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SHIFT_UP: begin
				if (ptr_q == req_q.position) begin
					state_d = ST_DRAIN;
				end
			end
			ST_SHIFT_DN: begin
				if (ptr_q + CNT_W'(1) == count_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = (req_q.func == FN_INSERT) ? ST_PUT : ST_DONE;
			ST_PUT:    state_d = ST_DONE;
			ST_LOCATE: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (ptr_q >= count_q && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_READ:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		rd_issue  = 1'b0;
		rd_addr   = ptr_q[ADDR_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = mem_rdata_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr  = req.position[ADDR_W-1:0];
				rd_issue = accept && (req.func == FN_READ) && rd_ok;
				cnt_dec  = accept && (req.func == FN_DELETE) && del_ok
					&& !(req.position + CNT_W'(1) < count_q);
			end
			ST_SHIFT_UP, ST_SHIFT_DN, ST_DRAIN: begin
				rd_issue = (state_q != ST_DRAIN);
				// write back the word fetched last cycle one place over
				mem_we    = rd_vld_s1;
				mem_waddr = (req_q.func == FN_INSERT) ? rd_addr_s1 + ADDR_W'(1)
				                                      : rd_addr_s1 - ADDR_W'(1);
				cnt_dec   = (state_q == ST_DRAIN) && (req_q.func == FN_DELETE);
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = req_q.position[ADDR_W-1:0];
				mem_wdata = req_q.value;
				cnt_inc   = 1'b1;
			end
			ST_LOCATE: begin
				rd_issue = !match && (ptr_q < count_q);
			end
			ST_READ: ;
			ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			cap_q     <= CAP_RESET;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// request capture, walk pointer and result fields
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (accept) begin
			req_q  <= req;
			fidx_q <= '0;
			rval_q <= '0;
			unique case (req.func)
				FN_INSERT: begin
					ok_q  <= ins_ok;
					ptr_q <= count_q - CNT_W'(1);
				end
				FN_DELETE: begin
					ok_q  <= del_ok;
					ptr_q <= req.position + CNT_W'(1);
				end
				FN_LOCATE: begin
					ok_q  <= 1'b0;
					ptr_q <= '0;
				end
				FN_READ: begin
					ok_q  <= rd_ok;
					ptr_q <= '0;
				end
				default: ok_q <= 1'b0;
			endcase
		end else begin
			unique case (state_q)
				ST_SHIFT_UP: ptr_q <= ptr_q - CNT_W'(1);
				ST_SHIFT_DN: ptr_q <= ptr_q + CNT_W'(1);
				ST_LOCATE: begin
					if (match) begin
						ok_q   <= 1'b1;
						fidx_q <= 6'(rd_addr_s1);
					end else if (rd_issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				ST_READ: rval_q <= mem_rdata_q;
				default: ;
			endcase
		end
	end

	// list store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[rd_addr];
	end

	always_comb begin
		res.ok          = ok_q;
		res.found_index = fidx_q;
		res.read_value  = rval_q;
		res.length      = 7'(count_q);
		res.empty_res   = (count_q == '0);
		res.full_res    = (count_q >= eff_cap);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list length above store depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_issue) |-> (mem_waddr != rd_addr))
		else $error("shift writes the entry being read");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a transfer");

endmodule

### tb/tb_ordered_array_list_table.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_ordered_array_list_table: self-checking bench for the positional word list
// Drives insert, delete, locate and read requests under several capacity
// settings, keeps its own copy of the list and compares every result field.
// -----------------------------------------------------------------------------
module tb_ordered_array_list_table;
	import oalt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 80;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	req_t       req       = '0;
	logic       cfg_we    = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic       done;
	res_t       res;

	// list contents as the block should hold them, and capacity as written
	logic signed [31:0] list_words[$];
	logic [6:0]         capacity_reg = 7'(DEPTH);
	res_t               pending_results[$];

	int items_sent    = 0;
	int results_seen  = 0;
	int fail_count    = 0;
	int cap_writes    = 0;
	int peak_length   = 0;
	int idle_cycles   = 0;
	bit burst_mode    = 1'b0;

	ordered_array_list_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.res       (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned effective_capacity();
		int unsigned c;
		c = capacity_reg;
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// apply one request to the list copy and return the result it should give
	function automatic res_t predict_list_op(input req_t r);
		res_t        o;
		int unsigned n;
		int unsigned cap;
		o   = '0;
		n   = list_words.size();
		cap = effective_capacity();
		case (r.func)
			FN_INSERT: begin
				if (r.position <= n && n < cap && n < DEPTH) begin
					list_words.insert(r.position, r.value);
					o.ok = 1'b1;
				end
			end
			FN_DELETE: begin
				if (r.position < n) begin
					list_words.delete(r.position);
					o.ok = 1'b1;
				end
			end
			FN_LOCATE: begin
				for (int j = 0; j < n; j++) begin
					if (list_words[j] == r.value) begin
						o.ok          = 1'b1;
						o.found_index = 6'(j);
						break;
					end
				end
			end
			FN_READ: begin
				if (r.position < n) begin
					o.read_value = list_words[r.position];
					o.ok         = 1'b1;
				end
			end
		endcase
		n           = list_words.size();
		o.length    = 7'(n);
		o.empty_res = (n == 0);
		o.full_res  = (n >= cap);
		if (n > peak_length) peak_length = n;
		return o;
	endfunction

	function automatic req_t mk_req(input func_t f, input int pos, input logic signed [31:0] v);
		req_t r;
		r.func     = f;
		r.position = 7'(pos);
		r.value    = v;
		return r;
	endfunction

	// mix of corner words, words already in the list and fully random words
	function automatic logic signed [31:0] pick_word();
		logic signed [31:0] corner_words[6];
		corner_words = '{32'sh0, 32'sh1, -32'sh1, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh5A5A_A5A5};
		case ($urandom_range(0, 3))
			0: return corner_words[$urandom_range(0, 5)];
			1: if (list_words.size() > 0)
				return list_words[$urandom_range(0, list_words.size() - 1)];
			default: ;
		endcase
		return $urandom;
	endfunction

	function automatic req_t make_random_req(input int wi, input int wd, input int wl,
		input int wr);
		req_t r;
		int   n;
		int   d;
		n = list_words.size();
		d = $urandom_range(0, wi + wd + wl + wr - 1);
		r = '0;
		r.value = pick_word();
		if (d < wi) begin
			r.func     = FN_INSERT;
			r.position = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, n))
				: 7'($urandom_range(0, 127));
		end else if (d < wi + wd + wr) begin
			r.func     = (d < wi + wd) ? FN_DELETE : FN_READ;
			r.position = (n > 0 && $urandom_range(0, 4) != 0) ? 7'($urandom_range(0, n - 1))
				: 7'($urandom_range(0, 127));
		end else begin
			r.func     = FN_LOCATE;
			r.position = 7'($urandom_range(0, 127));
			if (n > 0 && $urandom_range(0, 2) != 0)
				r.value = list_words[$urandom_range(0, n - 1)];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("%0t: result %0d %s mismatch: got 0x%0h, want 0x%0h",
			$time, results_seen, what, got, want);
	endtask

	// hold the request until the block takes it; start stays high afterwards
	task automatic send_request(input req_t r);
		int gap;
		if ($urandom_range(0, 23) == 0) burst_mode = ~burst_mode;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_list_op(r));
		items_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		capacity_reg  = v;
		cap_writes++;
	endtask

	task automatic test_empty_list_refusals();
		send_request(mk_req(FN_READ, 0, 32'sh1234_5678));
		send_request(mk_req(FN_DELETE, 0, 32'sh0));
		send_request(mk_req(FN_LOCATE, 0, 32'sh0));
		send_request(mk_req(FN_INSERT, 1, 32'sh11));
	endtask

	task automatic test_insert_and_locate();
		send_request(mk_req(FN_INSERT, 0, 32'sh8000_0000));
		send_request(mk_req(FN_INSERT, 1, 32'sh7FFF_FFFF));
		send_request(mk_req(FN_INSERT, 0, -32'sh1));
		// duplicate word: locate must report the lower index
		send_request(mk_req(FN_INSERT, 1, 32'sh7FFF_FFFF));
		send_request(mk_req(FN_INSERT, 127, 32'sh22));
		send_request(mk_req(FN_LOCATE, 0, 32'sh7FFF_FFFF));
		send_request(mk_req(FN_LOCATE, 127, -32'sh1));
		send_request(mk_req(FN_LOCATE, 0, 32'sh0));
	endtask

	task automatic test_read_delete_bounds();
		send_request(mk_req(FN_READ, 3, 32'sh0));
		send_request(mk_req(FN_READ, 4, 32'sh0));
		send_request(mk_req(FN_DELETE, 127, 32'sh0));
		send_request(mk_req(FN_DELETE, 1, 32'sh0));
		send_request(mk_req(FN_DELETE, 2, 32'sh0));
		send_request(mk_req(FN_READ, 0, 32'sh0));
	endtask

	task automatic test_capacity_extremes();
		// zero acts as one, and the list already holds more than that
		write_capacity(7'd0);
		send_request(mk_req(FN_INSERT, 0, 32'sh33));
		send_request(mk_req(FN_DELETE, 0, 32'sh0));
		send_request(mk_req(FN_DELETE, 0, 32'sh0));
		send_request(mk_req(FN_INSERT, 0, $urandom));
		send_request(mk_req(FN_INSERT, 1, 32'sh44));
		write_capacity(7'd1);
		send_request(mk_req(FN_INSERT, 0, 32'sh55));
	endtask

	task automatic run_random_mix(input int n_items, input int wi, input int wd,
		input int wl, input int wr);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 39) == 0) wait_drained();
			send_request(make_random_req(wi, wd, wl, wr));
		end
	endtask

	task automatic test_fill_beyond_depth();
		// above DEPTH acts as DEPTH: fill the store to the top
		write_capacity(7'd127);
		run_random_mix(160, 6, 1, 2, 2);
	endtask

	task automatic test_capacity_below_length();
		write_capacity(7'd8);
		run_random_mix(120, 1, 4, 2, 2);
	endtask

	task automatic test_random_settings();
		write_capacity(7'd0);
		run_random_mix(60, 3, 2, 2, 2);
		write_capacity(7'd65);
		run_random_mix(160, 5, 2, 2, 2);
		write_capacity(7'd64);
		run_random_mix(160, 3, 3, 2, 2);
		write_capacity(7'd20);
		run_random_mix(140, 4, 2, 2, 2);
	endtask

	// compare each result with the oldest outstanding prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested", res.read_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (res.ok !== want.ok)
					report_mismatch("ok", 32'(res.ok), 32'(want.ok));
				if (res.found_index !== want.found_index)
					report_mismatch("found_index", 32'(res.found_index),
						32'(want.found_index));
				if (res.read_value !== want.read_value)
					report_mismatch("read_value", res.read_value, want.read_value);
				if (res.length !== want.length)
					report_mismatch("length", 32'(res.length), 32'(want.length));
				if (res.empty_res !== want.empty_res)
					report_mismatch("empty_res", 32'(res.empty_res), 32'(want.empty_res));
				if (res.full_res !== want.full_res)
					report_mismatch("full_res", 32'(res.full_res), 32'(want.full_res));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired at %0t with %0d results outstanding",
					$time, pending_results.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list_refusals();
		test_insert_and_locate();
		test_read_delete_bounds();
		test_capacity_extremes();
		test_fill_beyond_depth();
		test_capacity_below_length();
		test_random_settings();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d list requests, checked %0d results across %0d capacity writes",
			items_sent, results_seen, cap_writes);
		$display("Longest list held %0d entries; %0d field mismatches",
			peak_length, fail_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
src/oalt_pkg.sv
src/ordered_array_list_table.sv
tb/tb_ordered_array_list_table.sv
